>>> sv/assert_macros.svh
// assertion helpers for the pendulum feedback block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("psf assertion failed");
`define PSF_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("psf assertion failed");
`else
`define PSF_ASSERT(label, clk, rst_n, prop)
`define PSF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> sv/psf_pkg.sv
`default_nettype none
package psf_pkg;
	localparam int COUNT_W = 16;
	localparam int FRAC_W = 16;
	localparam int ANG_W = 32;
	localparam int A_W = 34;
	localparam int B_W = 24;
	localparam int P_W = 58;
	localparam int MCNT_W = $clog2(B_W);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARM_ANGLE_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEND_ANGLE_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ARM_RATE_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PEND_RATE_GAIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd6;

	// radians per count in Q0.32, rounded
	localparam logic signed [A_W-1:0] ARM_SCALE = 34'sd42165743;
	localparam logic signed [A_W-1:0] PEND_SCALE = 34'sd11244198;
	localparam logic signed [P_W-1:0] HALF_LSB = 58'sd32768;
	localparam logic signed [P_W-1:0] PI_F = 58'sd205887;
	localparam logic signed [P_W-1:0] SAT_MAX = 58'sd2147483647;
	localparam logic signed [P_W-1:0] SAT_MIN = -58'sd2147483648;
	localparam logic signed [P_W-1:0] ONE_Q16 = 58'sd65536;

	// wrap reducer: bias is a multiple of two pi above 2^31
	localparam int WRAP_W = 34;
	localparam logic [WRAP_W-1:0] WRAP_BIAS = 34'd2147818400;
	localparam logic [WRAP_W-1:0] WRAP_DIV_INIT = 34'd3373260800;
	localparam logic [3:0] WRAP_LAST = 4'd13;
	localparam logic signed [19:0] PI_F20 = 20'sd205887;
	localparam logic signed [19:0] TWO_PI_F20 = 20'sd411775;

	typedef struct packed {
		logic start;
		logic signed [A_W-1:0] a;
		logic signed [B_W-1:0] b;
		logic signed [P_W-1:0] addend;
	} mul_req_t;

	function automatic logic signed [ANG_W-1:0] sat32(input logic signed [P_W-1:0] v);
		logic signed [P_W-1:0] t;
		t = v;
		if (v > SAT_MAX) t = SAT_MAX;
		if (v < SAT_MIN) t = SAT_MIN;
		return t[ANG_W-1:0];
	endfunction
endpackage
`default_nettype wire

>>> sv/pendulum_state_feedback_step.sv
// pendulum state feedback step
// input channel s_*: one item per control tick with the arm and pendulum
// encoder counts. output channel m_*: one result item per input item with
// duty, direction flags, clamped drive and the four filtered states.
// cfg_*: register writes (index, data), always ready; write only while idle.
// the work is done by one shared serial multiply-accumulate unit that
// takes one multiplier bit per cycle, with an issue and a write-back
// step around each product, and runs 12 products per item: angle
// scaling, four low-pass filters, two velocity products and four feedback
// terms. the pendulum angle wrap adds a 14-step serial reducer. the next
// item is taken once the sequencer is back in idle.
// a finished result waits in the output register while s_tready is high
// again; if the receiver stalls and a second item finishes, the block holds
// that item in its last step until the register drains.
// reset (arst_n low) clears the filter and history state to zero and loads
// the register defaults; no result is pending after reset.
`default_nettype none
`include "assert_macros.svh"
module pendulum_state_feedback_step (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // arm_count[15:0], pend_count[31:16]
	output logic m_tvalid,
	input wire logic m_tready,
	// duty[16:0], turn_cw[17], turn_ccw[18], drive[36:19],
	// arm_angle_filt[68:37], pend_angle_filt[87:69],
	// arm_rate_filt[119:88], pend_rate_filt[151:120]
	output logic [151:0] m_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [psf_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [psf_pkg::CFG_DATA_W-1:0] cfg_data
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_ISSUE, ST_MWAIT, ST_WRAP, ST_DONE
	} state_t;

	// sequencer steps
	localparam logic [3:0] STEP_ARM_SCALE = 4'd0;
	localparam logic [3:0] STEP_PEND_SCALE = 4'd1;
	localparam logic [3:0] STEP_ARM_LP = 4'd2;
	localparam logic [3:0] STEP_PEND_LP = 4'd3;
	localparam logic [3:0] STEP_ARM_RATE = 4'd4;
	localparam logic [3:0] STEP_ARM_RATE_LP = 4'd5;
	localparam logic [3:0] STEP_PEND_RATE = 4'd6;
	localparam logic [3:0] STEP_PEND_RATE_LP = 4'd7;
	localparam logic [3:0] STEP_K_ARM_ANGLE = 4'd8;
	localparam logic [3:0] STEP_K_PEND_ANGLE = 4'd9;
	localparam logic [3:0] STEP_K_ARM_RATE = 4'd10;
	localparam logic [3:0] STEP_K_PEND_RATE = 4'd11;

	state_t state_q;
	logic [3:0] step_q;

	// configuration
	logic [15:0] coeff_q;
	logic [13:0] rate_hz_q;
	logic signed [23:0] k_arm_angle_q, k_pend_angle_q, k_arm_rate_q, k_pend_rate_q;
	logic [16:0] limit_q;

	// captured counts
	logic signed [psf_pkg::COUNT_W-1:0] arm_c_q, pend_c_q;

	// controller state
	logic signed [31:0] arm_x_q, pend_x_q, last_arm_q, last_pend_q;
	logic signed [31:0] arm_lp_q, pend_lp_q, arm_rate_lp_q, pend_rate_lp_q;
	logic signed [31:0] rate_tmp_q;
	logic signed [psf_pkg::P_W-1:0] acc_q;
	logic signed [17:0] drive_q;

	// output register
	logic m_valid_q;
	logic [151:0] m_data_q;

	psf_pkg::mul_req_t mreq;
	logic mul_done;
	logic signed [psf_pkg::P_W-1:0] prod;
	logic signed [psf_pkg::P_W-1:0] prod_sh;
	logic wrap_start;
	logic signed [31:0] wrap_in;
	logic wrap_done;
	logic signed [18:0] wrap_res;
	logic signed [psf_pkg::P_W-1:0] pend_shift;
	logic signed [psf_pkg::P_W-1:0] lim, neg_d, clamped;
	logic [16:0] duty;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= 16'd52429;
			rate_hz_q <= 14'd100;
			k_arm_angle_q <= '0;
			k_pend_angle_q <= '0;
			k_arm_rate_q <= '0;
			k_pend_rate_q <= '0;
			limit_q <= 17'd32768;
		end else if (cfg_valid) begin
			case (cfg_index)
				psf_pkg::REG_FILTER_COEFF: coeff_q <= cfg_data[15:0];
				psf_pkg::REG_SAMPLE_RATE: rate_hz_q <= cfg_data[13:0];
				psf_pkg::REG_ARM_ANGLE_GAIN: k_arm_angle_q <= signed'(cfg_data);
				psf_pkg::REG_PEND_ANGLE_GAIN: k_pend_angle_q <= signed'(cfg_data);
				psf_pkg::REG_ARM_RATE_GAIN: k_arm_rate_q <= signed'(cfg_data);
				psf_pkg::REG_PEND_RATE_GAIN: k_pend_rate_q <= signed'(cfg_data);
				psf_pkg::REG_DRIVE_LIMIT: limit_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// operand selection for the shared multiplier: addend + a * b
	always_comb begin
		mreq.start = (state_q == ST_ISSUE);
		mreq.a = '0;
		mreq.b = '0;
		mreq.addend = '0;
		case (step_q)
			STEP_ARM_SCALE: begin
				mreq.a = psf_pkg::ARM_SCALE;
				mreq.b = psf_pkg::B_W'(arm_c_q);
				mreq.addend = psf_pkg::HALF_LSB;
			end
			STEP_PEND_SCALE: begin
				mreq.a = psf_pkg::PEND_SCALE;
				mreq.b = psf_pkg::B_W'(pend_c_q);
				mreq.addend = psf_pkg::HALF_LSB;
			end
			// low-pass as x + a * (prev - x), rounded
			STEP_ARM_LP: begin
				mreq.a = psf_pkg::A_W'(arm_lp_q) - psf_pkg::A_W'(arm_x_q);
				mreq.b = signed'({8'd0, coeff_q});
				mreq.addend = (psf_pkg::P_W'(arm_x_q) <<< psf_pkg::FRAC_W) + psf_pkg::HALF_LSB;
			end
			STEP_PEND_LP: begin
				mreq.a = psf_pkg::A_W'(pend_lp_q) - psf_pkg::A_W'(pend_x_q);
				mreq.b = signed'({8'd0, coeff_q});
				mreq.addend = (psf_pkg::P_W'(pend_x_q) <<< psf_pkg::FRAC_W) + psf_pkg::HALF_LSB;
			end
			STEP_ARM_RATE: begin
				mreq.a = psf_pkg::A_W'(arm_x_q) - psf_pkg::A_W'(last_arm_q);
				mreq.b = signed'({10'd0, rate_hz_q});
			end
			STEP_PEND_RATE: begin
				mreq.a = psf_pkg::A_W'(pend_x_q) - psf_pkg::A_W'(last_pend_q);
				mreq.b = signed'({10'd0, rate_hz_q});
			end
			STEP_ARM_RATE_LP: begin
				mreq.a = psf_pkg::A_W'(arm_rate_lp_q) - psf_pkg::A_W'(rate_tmp_q);
				mreq.b = signed'({8'd0, coeff_q});
				mreq.addend = (psf_pkg::P_W'(rate_tmp_q) <<< psf_pkg::FRAC_W)
					+ psf_pkg::HALF_LSB;
			end
			STEP_PEND_RATE_LP: begin
				mreq.a = psf_pkg::A_W'(pend_rate_lp_q) - psf_pkg::A_W'(rate_tmp_q);
				mreq.b = signed'({8'd0, coeff_q});
				mreq.addend = (psf_pkg::P_W'(rate_tmp_q) <<< psf_pkg::FRAC_W)
					+ psf_pkg::HALF_LSB;
			end
			// feedback terms accumulate through the addend
			STEP_K_ARM_ANGLE: begin
				mreq.a = psf_pkg::A_W'(arm_lp_q);
				mreq.b = k_arm_angle_q;
				mreq.addend = psf_pkg::HALF_LSB;
			end
			STEP_K_PEND_ANGLE: begin
				mreq.a = psf_pkg::A_W'(pend_lp_q);
				mreq.b = k_pend_angle_q;
				mreq.addend = acc_q;
			end
			STEP_K_ARM_RATE: begin
				mreq.a = psf_pkg::A_W'(arm_rate_lp_q);
				mreq.b = k_arm_rate_q;
				mreq.addend = acc_q;
			end
			STEP_K_PEND_RATE: begin
				mreq.a = psf_pkg::A_W'(pend_rate_lp_q);
				mreq.b = k_pend_rate_q;
				mreq.addend = acc_q;
			end
			default: ;
		endcase
	end

	psf_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.done(mul_done),
		.product(prod)
	);

	assign prod_sh = prod >>> psf_pkg::FRAC_W;
	// upright pendulum reads zero
	assign pend_shift = (prod_sh > 0) ? prod_sh - psf_pkg::PI_F : prod_sh + psf_pkg::PI_F;

	assign wrap_start = (state_q == ST_MWAIT) && mul_done && (step_q == STEP_PEND_LP);
	assign wrap_in = psf_pkg::sat32(prod_sh);

	psf_wrap u_wrap (
		.clk(clk),
		.arst_n(arst_n),
		.start(wrap_start),
		.value(wrap_in),
		.done(wrap_done),
		.result(wrap_res)
	);

	// drive = -(K . state), clamped to the limit (at most one)
	assign lim = (limit_q > 17'd65536) ? psf_pkg::ONE_Q16 : psf_pkg::P_W'(limit_q);
	assign neg_d = -prod_sh;
	always_comb begin
		clamped = neg_d;
		if (neg_d > lim) clamped = lim;
		if (neg_d < -lim) clamped = -lim;
	end
	assign duty = drive_q[17] ? 17'(-drive_q) : drive_q[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_ARM_SCALE;
			m_valid_q <= 1'b0;
			last_arm_q <= '0;
			last_pend_q <= '0;
			arm_lp_q <= '0;
			pend_lp_q <= '0;
			arm_rate_lp_q <= '0;
			pend_rate_lp_q <= '0;
		end else begin
			// result register loads in the last step, drains on the handshake
			if (state_q == ST_DONE && (!m_valid_q || m_tready)) m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						step_q <= STEP_ARM_SCALE;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (mul_done) begin
						step_q <= step_q + 1'b1;
						case (step_q)
							STEP_PEND_LP: state_q <= ST_WRAP;
							STEP_K_PEND_RATE: state_q <= ST_DONE;
							default: state_q <= ST_ISSUE;
						endcase
						case (step_q)
							STEP_ARM_LP: arm_lp_q <= psf_pkg::sat32(prod_sh);
							STEP_ARM_RATE: last_arm_q <= arm_x_q;
							STEP_ARM_RATE_LP: arm_rate_lp_q <= psf_pkg::sat32(prod_sh);
							STEP_PEND_RATE: last_pend_q <= pend_x_q;
							STEP_PEND_RATE_LP: pend_rate_lp_q <= psf_pkg::sat32(prod_sh);
							default: ;
						endcase
					end
				end
				ST_WRAP: begin
					if (wrap_done) begin
						pend_lp_q <= 32'(wrap_res);
						state_q <= ST_ISSUE;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			arm_c_q <= signed'(s_tdata[15:0]);
			pend_c_q <= signed'(s_tdata[31:16]);
		end
		if (state_q == ST_MWAIT && mul_done) begin
			case (step_q)
				STEP_ARM_SCALE: arm_x_q <= psf_pkg::sat32(prod_sh);
				STEP_PEND_SCALE: pend_x_q <= psf_pkg::sat32(pend_shift);
				STEP_ARM_RATE: rate_tmp_q <= psf_pkg::sat32(prod);
				STEP_PEND_RATE: rate_tmp_q <= psf_pkg::sat32(prod);
				STEP_K_PEND_RATE: drive_q <= clamped[17:0];
				default: acc_q <= prod;
			endcase
		end
		if (state_q == ST_DONE && (!m_valid_q || m_tready)) begin
			m_data_q <= {pend_rate_lp_q, arm_rate_lp_q, pend_lp_q[18:0], arm_lp_q,
				drive_q, (drive_q > 0), drive_q[17], duty};
		end
	end

	`PSF_ASSERT(a_mul_done_in_wait, clk, arst_n, mul_done |-> (state_q == ST_MWAIT))
	`PSF_ASSERT(a_wrap_range, clk, arst_n, wrap_done |-> (wrap_res <= 19'sd205887 && wrap_res >= -19'sd205887))
	`PSF_ASSERT(a_ready_not_busy, clk, arst_n, s_tready |-> (!mreq.start && !wrap_start))
	`PSF_ASSERT(a_duty_bound, clk, arst_n, m_tvalid |-> (m_tdata[16:0] <= 17'd65536))
endmodule
`default_nettype wire

>>> sv/psf_mul.sv
`default_nettype none
// serial shift-add multiply-accumulate, one multiplier bit per cycle
module psf_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire psf_pkg::mul_req_t req,
	output logic done,
	output logic signed [psf_pkg::P_W-1:0] product
);
	logic busy_q;
	logic done_q;
	logic [psf_pkg::MCNT_W-1:0] cnt_q;
	logic signed [psf_pkg::P_W-1:0] a_q;
	logic signed [psf_pkg::B_W-1:0] b_q;
	logic signed [psf_pkg::P_W-1:0] acc_q;
	logic last;
	logic signed [psf_pkg::P_W-1:0] term;

	assign last = (cnt_q == psf_pkg::MCNT_W'(psf_pkg::B_W - 1));
	// sign bit of the multiplier carries negative weight
	assign term = b_q[0] ? (last ? -a_q : a_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= psf_pkg::P_W'(req.a);
			b_q <= req.b;
			acc_q <= req.addend;
		end else if (busy_q) begin
			acc_q <= acc_q + term;
			a_q <= a_q <<< 1;
			b_q <= b_q >>> 1;
		end
	end

	assign done = done_q;
	assign product = acc_q;
endmodule
`default_nettype wire

>>> sv/psf_wrap.sv
`default_nettype none
// reduces an angle into [-pi, pi], one restoring subtract per cycle
module psf_wrap (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [psf_pkg::ANG_W-1:0] value,
	output logic done,
	output logic signed [18:0] result
);
	logic busy_q;
	logic done_q;
	logic [3:0] cnt_q;
	logic [psf_pkg::WRAP_W-1:0] r_q;
	logic [psf_pkg::WRAP_W-1:0] d_q;
	logic signed [19:0] rs;
	logic signed [19:0] res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == psf_pkg::WRAP_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == psf_pkg::WRAP_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= psf_pkg::WRAP_W'(value) + psf_pkg::WRAP_BIAS;
			d_q <= psf_pkg::WRAP_DIV_INIT;
		end else if (busy_q) begin
			if (r_q >= d_q) r_q <= r_q - d_q;
			d_q <= d_q >> 1;
		end
	end

	assign rs = signed'({1'b0, r_q[18:0]});
	assign res = (rs > psf_pkg::PI_F20) ? rs - psf_pkg::TWO_PI_F20 : rs;
	assign result = res[18:0];
	assign done = done_q;
endmodule
`default_nettype wire
